// ----- design/mra_pkg.sv -----
package mra_pkg;

	localparam int NUM_RATES   = 12;
	localparam int COUNT_WIDTH = 16;

	localparam int RATE_W = 4;
	localparam int IDX_W  = (NUM_RATES > 1) ? $clog2(NUM_RATES) : 1;
	localparam int LOSS_W = 16;
	localparam int THR_W  = 23;
	localparam int W_W    = 9;
	localparam int ACC_W  = LOSS_W + W_W;
	localparam int DCNT_W = $clog2(LOSS_W);

	localparam logic [RATE_W-1:0] RESET_RATE =
		(4 < NUM_RATES) ? RATE_W'(4) : RATE_W'(NUM_RATES - 1);
	localparam logic [W_W-1:0] RESET_WEIGHT = W_W'(128);
	localparam logic [W_W-1:0] WEIGHT_ONE   = W_W'(256);

	localparam logic CFG_FIXED_RATE = 1'b0;
	localparam logic CFG_WEIGHT     = 1'b1;

	typedef struct packed {
		logic load;
		logic div_step;
		logic mul_a;
		logic mul_b;
		logic thr_upd;
		logic scan_step;
		logic finish;
	} mra_cmd_t;

	typedef struct packed {
		logic div_last;
		logic scan_last;
	} mra_sts_t;

	// PHY rate in units of 0.5 Mbps; indices twelve and above carry no rate
	function automatic logic [6:0] rate_half_mbps(input logic [RATE_W-1:0] r);
		logic [6:0] v;
		unique case (r)
			4'd0:    v = 7'd2;
			4'd1:    v = 7'd4;
			4'd2:    v = 7'd11;
			4'd3:    v = 7'd22;
			4'd4:    v = 7'd12;
			4'd5:    v = 7'd18;
			4'd6:    v = 7'd24;
			4'd7:    v = 7'd36;
			4'd8:    v = 7'd48;
			4'd9:    v = 7'd72;
			4'd10:   v = 7'd96;
			4'd11:   v = 7'd104;
			default: v = 7'd0;
		endcase
		return v;
	endfunction

	function automatic logic [RATE_W-1:0] clamp_rate(input logic [RATE_W-1:0] r);
		logic [RATE_W:0] lim;
		lim = (RATE_W+1)'(NUM_RATES);
		return ({1'b0, r} >= lim) ? RATE_W'(NUM_RATES - 1) : r;
	endfunction

endpackage

// ----- design/mra_ctrl.sv -----
module mra_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	output logic              out_valid,
	input  logic              out_ready,
	input  mra_pkg::mra_sts_t sts,
	output mra_pkg::mra_cmd_t cmd
);
	import mra_pkg::*;

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_DIV  = 3'd1;
	localparam logic [2:0] S_MULA = 3'd2;
	localparam logic [2:0] S_MULB = 3'd3;
	localparam logic [2:0] S_THR  = 3'd4;
	localparam logic [2:0] S_SCAN = 3'd5;
	localparam logic [2:0] S_FIN  = 3'd6;

	logic [2:0] state_q, state_nxt;
	logic       out_valid_q;
	logic       fin_ok;

	// result register frees up when empty or when its beat is taken now
	assign fin_ok = !out_valid_q || out_ready;

	always_comb begin
		cmd           = '0;
		state_nxt     = state_q;
		unique case (state_q)
			S_IDLE: begin
				cmd.load = in_valid;
				if (in_valid) state_nxt = S_DIV;
			end
			S_DIV: begin
				cmd.div_step = 1'b1;
				if (sts.div_last) state_nxt = S_MULA;
			end
			S_MULA: begin
				cmd.mul_a = 1'b1;
				state_nxt = S_MULB;
			end
			S_MULB: begin
				cmd.mul_b = 1'b1;
				state_nxt = S_THR;
			end
			S_THR: begin
				cmd.thr_upd = 1'b1;
				state_nxt   = S_SCAN;
			end
			S_SCAN: begin
				cmd.scan_step = 1'b1;
				if (sts.scan_last) state_nxt = S_FIN;
			end
			S_FIN: begin
				cmd.finish = fin_ok;
				if (fin_ok) state_nxt = S_IDLE;
			end
			default: state_nxt = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (cmd.finish) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;

endmodule

// ----- design/mra_datapath.sv -----
module mra_datapath (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_we,
	input  logic                                 cfg_index,
	input  logic [mra_pkg::W_W-1:0]              cfg_data,
	input  logic [mra_pkg::COUNT_WIDTH-1:0]      sent_count,
	input  logic [mra_pkg::COUNT_WIDTH-1:0]      received_count,
	input  logic [7:0]                           source_byte,
	input  logic                                 leader_claim,
	input  mra_pkg::mra_cmd_t                    cmd,
	output mra_pkg::mra_sts_t                    sts,
	output logic                                 rate_changed,
	output logic [mra_pkg::RATE_W-1:0]           new_rate,
	output logic [mra_pkg::RATE_W-1:0]           previous_rate,
	output logic [12:0]                          ttl_word,
	output logic [mra_pkg::LOSS_W-1:0]           loss_estimate
);
	import mra_pkg::*;

	logic [RATE_W-1:0]      fixed_q;
	logic [W_W-1:0]         weight_q;
	logic [LOSS_W-1:0]      loss_tab_q [NUM_RATES];
	logic [THR_W-1:0]       thr_tab_q  [NUM_RATES];
	logic [RATE_W-1:0]      cur_q;
	logic [7:0]             leader_q;

	logic [COUNT_WIDTH-1:0] sent_q;
	logic [COUNT_WIDTH-1:0] rem_q;
	logic [LOSS_W-1:0]      quot_q;
	logic                   zero_q;
	logic [DCNT_W-1:0]      dcnt_q;
	logic [ACC_W-1:0]       acc_q;
	logic [IDX_W-1:0]       idx_q;
	logic [RATE_W-1:0]      best_q;
	logic [THR_W-1:0]       best_thr_q;
	logic [RATE_W-1:0]      prev_q;
	logic [LOSS_W-1:0]      loss_new_q;

	logic [W_W-1:0]         w_sat;
	logic [W_W-1:0]         w_inv;
	logic [LOSS_W-1:0]      inst;
	logic [COUNT_WIDTH:0]   shifted;
	logic                   sub_ok;
	logic [LOSS_W-1:0]      loss_new;
	logic [LOSS_W:0]        one_minus;
	logic [THR_W:0]         thr_prod;
	logic [IDX_W-1:0]       cur_idx;
	logic [THR_W-1:0]       scan_thr;
	logic [RATE_W-1:0]      final_rate;

	assign w_sat    = (weight_q > WEIGHT_ONE) ? WEIGHT_ONE : weight_q;
	assign w_inv    = WEIGHT_ONE - w_sat;
	assign inst     = zero_q ? '0 : quot_q;
	assign cur_idx  = cur_q[IDX_W-1:0];

	// restoring divide, one quotient bit per step
	assign shifted  = {rem_q, 1'b0};
	assign sub_ok   = (shifted >= {1'b0, sent_q});

	assign loss_new  = acc_q[LOSS_W+7:8];
	assign one_minus = (LOSS_W+1)'(1 << LOSS_W) - {1'b0, loss_new};
	assign thr_prod  = (THR_W+1)'(rate_half_mbps(cur_q)) * (THR_W+1)'(one_minus);

	assign scan_thr   = thr_tab_q[idx_q];
	assign final_rate = (fixed_q != '0) ? clamp_rate(fixed_q) : best_q;

	assign sts.div_last  = (dcnt_q == DCNT_W'(LOSS_W - 1));
	assign sts.scan_last = (idx_q == IDX_W'(NUM_RATES - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fixed_q  <= '0;
			weight_q <= RESET_WEIGHT;
			cur_q    <= RESET_RATE;
			leader_q <= '0;
			for (int i = 0; i < NUM_RATES; i++) begin
				loss_tab_q[i] <= '0;
				thr_tab_q[i]  <= '0;
			end
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					CFG_FIXED_RATE: fixed_q  <= cfg_data[RATE_W-1:0];
					CFG_WEIGHT:     weight_q <= cfg_data;
					default:        ;
				endcase
			end
			if (cmd.load && (leader_q == '0 || leader_claim)) leader_q <= source_byte;
			if (cmd.thr_upd) begin
				loss_tab_q[cur_idx] <= loss_new;
				thr_tab_q[cur_idx]  <= thr_prod[THR_W-1:0];
			end
			if (cmd.finish) cur_q <= final_rate;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			sent_q <= sent_count;
			rem_q  <= sent_count - received_count;
			zero_q <= (received_count == '0) || (received_count > sent_count);
			dcnt_q <= '0;
		end
		if (cmd.div_step) begin
			rem_q  <= sub_ok ? COUNT_WIDTH'(shifted - {1'b0, sent_q})
			                 : shifted[COUNT_WIDTH-1:0];
			quot_q <= {quot_q[LOSS_W-2:0], sub_ok};
			dcnt_q <= dcnt_q + 1'b1;
		end
		if (cmd.mul_a)
			acc_q <= ACC_W'(w_sat) * ACC_W'(loss_tab_q[cur_idx]);
		if (cmd.mul_b)
			acc_q <= acc_q + ACC_W'(w_inv) * ACC_W'(inst) + ACC_W'(128);
		if (cmd.thr_upd) begin
			loss_new_q <= loss_new;
			prev_q     <= cur_q;
			best_q     <= cur_q;
			best_thr_q <= thr_prod[THR_W-1:0];
			idx_q      <= '0;
		end
		if (cmd.scan_step) begin
			if (scan_thr > best_thr_q) begin
				best_q     <= RATE_W'(idx_q);
				best_thr_q <= scan_thr;
			end
			idx_q <= idx_q + 1'b1;
		end
		if (cmd.finish) begin
			rate_changed  <= (final_rate != prev_q);
			new_rate      <= final_rate;
			previous_rate <= prev_q;
			ttl_word      <= {leader_q, 5'b0} | ({8'b0, final_rate, 1'b0} + 13'd5);
			loss_estimate <= loss_new_q;
		end
	end

endmodule

// ----- design/multicast_rate_adapter.sv -----
// channel  | handshake           | payload
// ---------+---------------------+-----------------------------------------------
// in       | in_valid/in_ready   | sent_count, received_count, source_byte,
//          |                     | leader_claim
// out      | out_valid/out_ready | rate_changed, new_rate, previous_rate,
//          |                     | ttl_word, loss_estimate
// cfg      | cfg_we (no stall)   | cfg_index, cfg_data
//
// One report at a time: a 16-bit restoring divide, the two EWMA multiplies, the
// throughput update, one step per rate for the scan, then the result register
// loads; the divide and scan dominate the time from accept to result beat.
// A new beat is taken while the previous result still waits on out_ready.
// Reset clears both rate tables, sets the rate to 4 and the weight to 128.
module multicast_rate_adapter (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic                            cfg_index,
	input  logic [mra_pkg::W_W-1:0]         cfg_data,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic [mra_pkg::COUNT_WIDTH-1:0] sent_count,
	input  logic [mra_pkg::COUNT_WIDTH-1:0] received_count,
	input  logic [7:0]                      source_byte,
	input  logic                            leader_claim,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic                            rate_changed,
	output logic [mra_pkg::RATE_W-1:0]      new_rate,
	output logic [mra_pkg::RATE_W-1:0]      previous_rate,
	output logic [12:0]                     ttl_word,
	output logic [mra_pkg::LOSS_W-1:0]      loss_estimate
);
	import mra_pkg::*;

	mra_cmd_t cmd;
	mra_sts_t sts;

	mra_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	mra_datapath u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.sent_count     (sent_count),
		.received_count (received_count),
		.source_byte    (source_byte),
		.leader_claim   (leader_claim),
		.cmd            (cmd),
		.sts            (sts),
		.rate_changed   (rate_changed),
		.new_rate       (new_rate),
		.previous_rate  (previous_rate),
		.ttl_word       (ttl_word),
		.loss_estimate  (loss_estimate)
	);

endmodule

// ----- sim/tb.sv -----
`timescale 1ns / 100ps

module tb;

	import mra_pkg::*;

	typedef struct packed {
		logic              changed;
		logic [RATE_W-1:0] new_r;
		logic [RATE_W-1:0] prev_r;
		logic [12:0]       ttl;
		logic [LOSS_W-1:0] loss;
	} rate_report_t;

	typedef struct {
		bit                     is_write;
		logic                   reg_sel;
		logic [W_W-1:0]         value;
		logic [COUNT_WIDTH-1:0] sent;
		logic [COUNT_WIDTH-1:0] recv;
		logic [7:0]             src;
		logic                   claim;
		bit                     typed;
		rate_report_t           want;
	} plan_row_t;

	// PHY rates in half-Mbps steps; slots past the last rate carry nothing
	localparam int unsigned HALF_MBPS_TBL [16] =
		'{2, 4, 11, 22, 12, 18, 24, 36, 48, 72, 96, 104, 0, 0, 0, 0};

	logic                   clk;
	logic                   arst_n;
	logic                   cfg_we;
	logic                   cfg_index;
	logic [W_W-1:0]         cfg_data;
	logic                   in_valid;
	logic                   in_ready;
	logic [COUNT_WIDTH-1:0] sent_count;
	logic [COUNT_WIDTH-1:0] received_count;
	logic [7:0]             source_byte;
	logic                   leader_claim;
	logic                   out_valid;
	logic                   out_ready;
	logic                   rate_changed;
	logic [RATE_W-1:0]      new_rate;
	logic [RATE_W-1:0]      previous_rate;
	logic [12:0]            ttl_word;
	logic [LOSS_W-1:0]      loss_estimate;

	// predictor state
	logic [LOSS_W-1:0] loss_est [16];
	logic [THR_W-1:0]  goodput [16];
	logic [RATE_W-1:0] rate_now;
	logic [7:0]        leader;
	logic [3:0]        fixed_cfg;
	logic [W_W-1:0]    weight_cfg;

	rate_report_t pending_reports [$];
	plan_row_t    directed [$];
	int unsigned  faults = 0;
	bit           steady;

	multicast_rate_adapter uut (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.sent_count     (sent_count),
		.received_count (received_count),
		.source_byte    (source_byte),
		.leader_claim   (leader_claim),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.rate_changed   (rate_changed),
		.new_rate       (new_rate),
		.previous_rate  (previous_rate),
		.ttl_word       (ttl_word),
		.loss_estimate  (loss_estimate)
	);

	always begin
		clk = 1'b0;
		#1;
		clk = 1'b1;
		#1;
	end

	initial begin
		#2000000;
		$display("[FAIL] regression broken");
		$finish;
	end

	function automatic void clear_model();
		for (int i = 0; i < 16; i++) begin
			loss_est[i] = '0;
			goodput[i]  = '0;
		end
		rate_now   = RESET_RATE;
		leader     = '0;
		fixed_cfg  = '0;
		weight_cfg = RESET_WEIGHT;
	endfunction

	function automatic rate_report_t predict_report(input logic [COUNT_WIDTH-1:0] sent,
			input logic [COUNT_WIDTH-1:0] recv, input logic [7:0] src, input logic claim);
		int unsigned w;
		int unsigned inst;
		int unsigned acc;
		logic [RATE_W-1:0] cur;
		logic [RATE_W-1:0] prev;
		rate_report_t r;
		w   = (weight_cfg > 256) ? 256 : weight_cfg;
		cur = (rate_now >= NUM_RATES) ? RATE_W'(NUM_RATES - 1) : rate_now;
		if (leader == 0 || claim)
			leader = src;
		inst = 0;
		// no reception, or more received than sent, counts as lossless
		if (recv != 0 && recv <= sent)
			inst = ((32'(sent) - 32'(recv)) << 16) / 32'(sent);
		acc = w * loss_est[cur] + (256 - w) * inst + 128;
		loss_est[cur] = acc[23:8];
		goodput[cur]  = THR_W'(HALF_MBPS_TBL[cur] * (65536 - 32'(loss_est[cur])));
		prev = cur;
		// greedy: cur moves during the scan
		for (int i = 0; i < NUM_RATES && i < 16; i++) begin
			if (goodput[i] > goodput[cur])
				cur = RATE_W'(i);
		end
		if (fixed_cfg != 0)
			cur = (fixed_cfg >= NUM_RATES) ? RATE_W'(NUM_RATES - 1) : fixed_cfg;
		rate_now = cur;
		r.changed = (cur != prev);
		r.new_r   = cur;
		r.prev_r  = prev;
		r.ttl     = 13'((2 * 32'(cur) + 5) | (32'(leader) << 5));
		r.loss    = loss_est[prev];
		return r;
	endfunction

	function automatic void plan_report(input logic [COUNT_WIDTH-1:0] s,
			input logic [COUNT_WIDTH-1:0] r, input logic [7:0] b, input logic c,
			input bit typed, input rate_report_t want);
		plan_row_t row;
		row = '{is_write: 1'b0, reg_sel: 1'b0, value: '0, sent: s, recv: r, src: b,
			claim: c, typed: typed, want: want};
		directed.push_back(row);
	endfunction

	function automatic void plan_write(input logic sel, input logic [W_W-1:0] v);
		plan_row_t row;
		row = '{is_write: 1'b1, reg_sel: sel, value: v, sent: '0, recv: '0, src: '0,
			claim: 1'b0, typed: 1'b0, want: '0};
		directed.push_back(row);
	endfunction

	task automatic send_report(input logic [COUNT_WIDTH-1:0] s,
			input logic [COUNT_WIDTH-1:0] r, input logic [7:0] b, input logic c,
			input bit typed, input rate_report_t want);
		rate_report_t guess;
		while (!steady && $urandom_range(99) < 16) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid       <= 1'b1;
		sent_count     <= s;
		received_count <= r;
		source_byte    <= b;
		leader_claim   <= c;
		do @(posedge clk); while (!in_ready);
		guess = predict_report(s, r, b, c);
		pending_reports.push_back(typed ? want : guess);
	endtask

	// registers change only with the block idle: drain every pending beat first
	task automatic write_reg(input logic sel, input logic [W_W-1:0] v);
		in_valid <= 1'b0;
		while (pending_reports.size() != 0)
			@(posedge clk);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= sel;
		cfg_data  <= v;
		@(posedge clk);
		if (sel == CFG_FIXED_RATE)
			fixed_cfg = v[3:0];
		else
			weight_cfg = v;
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	always @(posedge clk) begin
		out_ready <= steady ? 1'b1 : ($urandom_range(99) >= 16);
	end

	always @(posedge clk) begin : watch_results
		rate_report_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_reports.size() == 0) begin
				$error("result beat with nothing expected");
				faults++;
			end else begin
				want = pending_reports.pop_front();
				if (rate_changed !== want.changed) begin
					$error("rate_changed: expected %0d, got %0d", want.changed, rate_changed);
					faults++;
				end
				if (new_rate !== want.new_r) begin
					$error("new_rate: expected %0d, got %0d", want.new_r, new_rate);
					faults++;
				end
				if (previous_rate !== want.prev_r) begin
					$error("previous_rate: expected %0d, got %0d", want.prev_r,
						previous_rate);
					faults++;
				end
				if (ttl_word !== want.ttl) begin
					$error("ttl_word: expected %0d, got %0d", want.ttl, ttl_word);
					faults++;
				end
				if (loss_estimate !== want.loss) begin
					$error("loss_estimate: expected %0d, got %0d", want.loss,
						loss_estimate);
					faults++;
				end
			end
		end
	end

	initial begin : stimulus
		logic [COUNT_WIDTH-1:0] s;
		logic [COUNT_WIDTH-1:0] r;
		logic [W_W-1:0] wv;
		int unsigned pick;
		plan_row_t row;

		steady = 1'b0;
		arst_n         <= 1'b0;
		cfg_we         <= 1'b0;
		cfg_index      <= CFG_FIXED_RATE;
		cfg_data       <= '0;
		in_valid       <= 1'b0;
		sent_count     <= '0;
		received_count <= '0;
		source_byte    <= '0;
		leader_claim   <= 1'b0;
		clear_model();

		// after reset: rate 4, empty tables, no leader yet
		plan_report(16'd0, 16'd0, 8'h00, 1'b0, 1'b1, {1'b0, 4'd4, 4'd4, 13'd13, 16'd0});
		plan_report(16'd100, 16'd100, 8'hFF, 1'b0, 1'b1,
			{1'b0, 4'd4, 4'd4, 13'd8173, 16'd0});
		plan_report(16'hFFFF, 16'd1, 8'h12, 1'b0, 1'b0, '0);
		plan_report(16'd10, 16'd20, 8'h34, 1'b1, 1'b0, '0);
		plan_report(16'd0, 16'd5, 8'h56, 1'b0, 1'b0, '0);
		plan_report(16'hFFFF, 16'd0, 8'h00, 1'b1, 1'b0, '0);
		plan_report(16'hFFFF, 16'hFFFF, 8'hA5, 1'b0, 1'b0, '0);
		// forced rate applies at the end of the next report
		plan_write(CFG_FIXED_RATE, 9'd11);
		plan_report(16'd1000, 16'd900, 8'h5A, 1'b0, 1'b0, '0);
		plan_report(16'd1000, 16'd1000, 8'hC3, 1'b1, 1'b0, '0);
		plan_write(CFG_FIXED_RATE, 9'd15);
		plan_report(16'd500, 16'd250, 8'h3C, 1'b0, 1'b0, '0);
		plan_write(CFG_FIXED_RATE, 9'd0);
		plan_report(16'd2000, 16'd1000, 8'h81, 1'b0, 1'b0, '0);
		plan_write(CFG_WEIGHT, 9'd0);
		plan_report(16'hFFFF, 16'h8000, 8'h7E, 1'b0, 1'b0, '0);
		plan_write(CFG_WEIGHT, 9'd256);
		plan_report(16'd100, 16'd1, 8'h01, 1'b0, 1'b0, '0);
		plan_write(CFG_WEIGHT, 9'h1FF);
		plan_report(16'd100, 16'd50, 8'hFE, 1'b1, 1'b0, '0);
		plan_write(CFG_WEIGHT, 9'd128);
		plan_write(CFG_FIXED_RATE, 9'd1);
		plan_report(16'd300, 16'd299, 8'h44, 1'b0, 1'b0, '0);
		plan_write(CFG_FIXED_RATE, 9'd0);
		plan_report(16'd40, 16'd10, 8'h99, 1'b0, 1'b0, '0);

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		foreach (directed[i]) begin
			row = directed[i];
			if (row.is_write)
				write_reg(row.reg_sel, row.value);
			else
				send_report(row.sent, row.recv, row.src, row.claim, row.typed, row.want);
		end

		for (int phase = 0; phase < 13; phase++) begin
			steady = (phase == 5 || phase == 6);
			write_reg(CFG_FIXED_RATE, $urandom_range(1) ? 9'd0 : W_W'($urandom_range(15, 1)));
			case ($urandom_range(4))
				0:       wv = 9'd0;
				1:       wv = 9'd256;
				2:       wv = 9'h1FF;
				default: wv = W_W'($urandom_range(511));
			endcase
			write_reg(CFG_WEIGHT, wv);
			for (int n = 0; n < 50; n++) begin
				pick = $urandom_range(99);
				if (pick < 8) begin
					s = '0;
					r = COUNT_WIDTH'($urandom);
				end else if (pick < 16) begin
					s = COUNT_WIDTH'($urandom);
					r = '0;
				end else if (pick < 24) begin
					s = COUNT_WIDTH'($urandom_range(65534));
					r = COUNT_WIDTH'($urandom_range(65535, 32'(s) + 1));
				end else if (pick < 32) begin
					case ($urandom_range(2))
						0:       s = '0;
						1:       s = 16'd1;
						default: s = '1;
					endcase
					case ($urandom_range(2))
						0:       r = '0;
						1:       r = 16'd1;
						default: r = '1;
					endcase
				end else begin
					// mostly light loss, so the scan has real winners to move to
					s = $urandom_range(1) ? COUNT_WIDTH'($urandom_range(200, 1))
						: COUNT_WIDTH'($urandom_range(65535, 1));
					r = $urandom_range(3) ? COUNT_WIDTH'($urandom_range(s, s - s / 4))
						: COUNT_WIDTH'($urandom_range(s));
				end
				send_report(s, r, 8'($urandom), ($urandom_range(9) == 0), 1'b0, '0);
			end
		end

		steady = 1'b0;
		in_valid <= 1'b0;
		while (pending_reports.size() != 0)
			@(posedge clk);
		repeat (40) @(posedge clk);
		if (faults == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
